FILE: src/gelu_pkg.sv
// gelu_pkg: shared widths, constants, beat types and tanh table for the gelu pipeline
package gelu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 11;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int MAG_W   = (DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3;
    localparam int SHIFT_L = (FRAC_BITS <= 16) ? (16 - FRAC_BITS) : 0;
    localparam int SHIFT_R = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;

    localparam int A16_W      = 19;
    localparam int SQ_W       = 21;
    localparam int T_W        = 17;
    localparam int P_W        = 19;
    localparam int U_W        = 19;
    localparam int SEG_BITS   = 13;
    localparam int IDX_W      = U_W - SEG_BITS;
    localparam int TANH_STEPS = 32;
    localparam int TH_W       = 16;
    localparam int DIFF_W     = 12;
    localparam int M_W        = 17;
    localparam int CUBIC_W    = 12;
    localparam int SCALE_W    = 16;

    localparam logic [MAG_W-1:0]   MAG_LIMIT    = MAG_W'(64'd4 << FRAC_BITS);
    localparam logic [CUBIC_W-1:0] COEF_CUBIC   = CUBIC_W'(2930);
    localparam logic [SCALE_W-1:0] COEF_SCALE   = SCALE_W'(52290);
    localparam logic [TH_W-1:0]    ONE_Q15      = TH_W'(32768);
    localparam logic [M_W-1:0]     ONE_Q16      = M_W'(65536);
    localparam int                 INTERP_ROUND = 4096;

    typedef logic signed [DATA_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t        x;
        logic           last;
        logic [U_W-1:0] u;
    } poly_beat_t;

    typedef struct packed {
        sample_t        x;
        logic           last;
        logic [M_W-1:0] m;
    } scale_beat_t;

    // tanh in q15 over [0, 4] in steps of 1/8
    function automatic logic [TH_W-1:0] tanh_entry(input logic [IDX_W-1:0] i);
        logic [TH_W-1:0] v;
        case (i)
            0:  v = TH_W'(0);
            1:  v = TH_W'(4075);
            2:  v = TH_W'(8025);
            3:  v = TH_W'(11743);
            4:  v = TH_W'(15143);
            5:  v = TH_W'(18173);
            6:  v = TH_W'(20813);
            7:  v = TH_W'(23066);
            8:  v = TH_W'(24956);
            9:  v = TH_W'(26519);
            10: v = TH_W'(27797);
            11: v = TH_W'(28830);
            12: v = TH_W'(29660);
            13: v = TH_W'(30322);
            14: v = TH_W'(30847);
            15: v = TH_W'(31262);
            16: v = TH_W'(31589);
            17: v = TH_W'(31846);
            18: v = TH_W'(32048);
            19: v = TH_W'(32206);
            20: v = TH_W'(32329);
            21: v = TH_W'(32426);
            22: v = TH_W'(32501);
            23: v = TH_W'(32560);
            24: v = TH_W'(32606);
            25: v = TH_W'(32642);
            26: v = TH_W'(32670);
            27: v = TH_W'(32691);
            28: v = TH_W'(32708);
            29: v = TH_W'(32721);
            30: v = TH_W'(32732);
            31: v = TH_W'(32740);
            32: v = TH_W'(32746);
            default: v = ONE_Q15;
        endcase
        return v;
    endfunction

endpackage

FILE: src/gelu_tanh_activation_top.sv
// gelu_tanh_activation_top: streaming tanh-approximated gelu over q4.11 samples
// Applies y = 0.5*x*(1 + tanh(sqrt(2/pi)*x*(1 + 0.044715*x^2))) to each beat, signed
// q4.11 in and out, rounded to nearest and saturated; tanh comes from a 33-entry
// table over [0, 4] with linear interpolation and is exactly +-1 beyond. tlast passes
// through with its sample. One beat is accepted per cycle while backpressure does not
// stall the pipeline; each result passes through eight register stages (five for the
// polynomial multiplies, two for table lookup and interpolation, one for the final
// multiply and rounding). Backpressure stalls only the stages that hold data, so
// bubbles are squeezed out and results come in input order.
module gelu_tanh_activation_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [gelu_pkg::TDATA_W-1:0] s_axis_tdata,  // sample
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [gelu_pkg::TDATA_W-1:0] m_axis_tdata,  // activated
    output logic                         m_axis_tlast
);

    logic                  poly_valid, poly_ready;
    gelu_pkg::poly_beat_t  poly_beat;
    logic                  tanh_valid, tanh_ready;
    gelu_pkg::scale_beat_t tanh_beat;
    gelu_pkg::sample_t     sample;
    gelu_pkg::sample_t     activated;

    assign sample = s_axis_tdata[gelu_pkg::DATA_WIDTH-1:0];

    gelu_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (sample),
        .in_last   (s_axis_tlast),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_beat  (poly_beat)
    );

    gelu_tanh u_tanh (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_beat   (poly_beat),
        .out_valid (tanh_valid),
        .out_ready (tanh_ready),
        .out_beat  (tanh_beat)
    );

    gelu_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tanh_valid),
        .in_ready  (tanh_ready),
        .in_beat   (tanh_beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .activated (activated),
        .last_out  (m_axis_tlast)
    );

    assign m_axis_tdata = gelu_pkg::TDATA_W'(unsigned'(activated));

endmodule

FILE: src/gelu_poly.sv
// gelu_poly: five-stage pipeline forming the scaled tanh argument from |x|
module gelu_poly (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gelu_pkg::sample_t    in_sample,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gelu_pkg::poly_beat_t out_beat
);

    localparam int WIDE_W = gelu_pkg::MAG_W + 16;
    localparam int SQP_W  = 2 * gelu_pkg::A16_W;
    localparam int CUBP_W = gelu_pkg::CUBIC_W + gelu_pkg::SQ_W;
    localparam int PP_W   = gelu_pkg::A16_W + gelu_pkg::T_W;
    localparam int UP_W   = gelu_pkg::SCALE_W + gelu_pkg::P_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    gelu_pkg::sample_t x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;

    logic signed [gelu_pkg::MAG_W-1:0] x_ext;
    logic [gelu_pkg::MAG_W-1:0]  mag;
    logic [gelu_pkg::MAG_W-1:0]  mag_clamped;
    logic [WIDE_W-1:0]           a16_wide;
    logic [gelu_pkg::A16_W-1:0]  a16_next, a16_1_reg, a16_2_reg, a16_3_reg;
    logic [SQP_W-1:0]            sq_prod;
    logic [gelu_pkg::SQ_W-1:0]   sq_next, sq_reg;
    logic [CUBP_W-1:0]           cub_prod;
    logic [gelu_pkg::T_W-1:0]    t_next, t_reg;
    logic [PP_W-1:0]             p_prod;
    logic [gelu_pkg::P_W-1:0]    p_next, p_reg;
    logic [UP_W-1:0]             u_prod;
    logic [gelu_pkg::U_W-1:0]    u_next, u_reg;

    assign en5 = !v5_reg || out_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // magnitude, clamp to 4.0, move to 16 fractional bits
    always_comb
    begin
        x_ext       = gelu_pkg::MAG_W'(in_sample);
        mag         = x_ext[gelu_pkg::MAG_W-1] ? gelu_pkg::MAG_W'(-x_ext)
                                               : gelu_pkg::MAG_W'(x_ext);
        mag_clamped = (mag > gelu_pkg::MAG_LIMIT) ? gelu_pkg::MAG_LIMIT : mag;
        a16_wide    = (WIDE_W'(mag_clamped) << gelu_pkg::SHIFT_L) >> gelu_pkg::SHIFT_R;
        a16_next    = a16_wide[gelu_pkg::A16_W-1:0];
    end

    always_comb
    begin
        sq_prod  = SQP_W'(a16_1_reg) * SQP_W'(a16_1_reg);
        sq_next  = sq_prod[16 +: gelu_pkg::SQ_W];
        cub_prod = CUBP_W'(gelu_pkg::COEF_CUBIC) * CUBP_W'(sq_reg);
        t_next   = gelu_pkg::ONE_Q16 + cub_prod[16 +: gelu_pkg::T_W];
        p_prod   = PP_W'(a16_3_reg) * PP_W'(t_reg);
        p_next   = p_prod[16 +: gelu_pkg::P_W];
        u_prod   = UP_W'(gelu_pkg::COEF_SCALE) * UP_W'(p_reg);
        u_next   = u_prod[16 +: gelu_pkg::U_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg    <= in_sample;
            last1_reg <= in_last;
            a16_1_reg <= a16_next;
        end
        if (en2)
        begin
            x2_reg    <= x1_reg;
            last2_reg <= last1_reg;
            a16_2_reg <= a16_1_reg;
            sq_reg    <= sq_next;
        end
        if (en3)
        begin
            x3_reg    <= x2_reg;
            last3_reg <= last2_reg;
            a16_3_reg <= a16_2_reg;
            t_reg     <= t_next;
        end
        if (en4)
        begin
            x4_reg    <= x3_reg;
            last4_reg <= last3_reg;
            p_reg     <= p_next;
        end
        if (en5)
        begin
            x5_reg    <= x4_reg;
            last5_reg <= last4_reg;
            u_reg     <= u_next;
        end
    end

    assign out_valid     = v5_reg;
    assign out_beat.x    = x5_reg;
    assign out_beat.last = last5_reg;
    assign out_beat.u    = u_reg;

endmodule

FILE: src/gelu_tanh.sv
// gelu_tanh: two-stage table lookup with linear interpolation, forms 1 +- tanh in q15, i.e. (1 +- tanh)/2 in q16
module gelu_tanh (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gelu_pkg::poly_beat_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gelu_pkg::scale_beat_t out_beat
);

    localparam int IP_W = gelu_pkg::DIFF_W + gelu_pkg::SEG_BITS + 1;

    logic v6_reg, v7_reg;
    logic en6, en7;

    logic [gelu_pkg::IDX_W-1:0]    idx;
    logic [gelu_pkg::IDX_W-1:0]    idx_hi;
    logic [gelu_pkg::TH_W-1:0]     lo_next, hi_val, lo_reg;
    logic [gelu_pkg::TH_W-1:0]     diff_full;
    logic [gelu_pkg::DIFF_W-1:0]   diff_next, diff_reg;
    logic [gelu_pkg::SEG_BITS-1:0] frac_reg;
    logic                          sat_next, sat_reg;
    gelu_pkg::sample_t             x6_reg, x7_reg;
    logic                          last6_reg, last7_reg;

    logic [IP_W-1:0]               interp;
    logic [gelu_pkg::TH_W-1:0]     th;
    logic [gelu_pkg::M_W-1:0]      m_next, m_reg;

    assign en7 = !v7_reg || out_ready;
    assign en6 = !v6_reg || en7;
    assign in_ready = en6;

    always_comb
    begin
        idx       = in_beat.u[gelu_pkg::U_W-1:gelu_pkg::SEG_BITS];
        idx_hi    = idx + gelu_pkg::IDX_W'(1);
        sat_next  = idx >= gelu_pkg::IDX_W'(gelu_pkg::TANH_STEPS);
        lo_next   = gelu_pkg::tanh_entry(idx);
        hi_val    = gelu_pkg::tanh_entry(idx_hi);
        diff_full = hi_val - lo_next;
        diff_next = diff_full[gelu_pkg::DIFF_W-1:0];
    end

    // rounded interpolation, then 1 + tanh or 1 - tanh by the sign of x
    always_comb
    begin
        interp = IP_W'(diff_reg) * IP_W'(frac_reg) + IP_W'(gelu_pkg::INTERP_ROUND);
        th     = sat_reg ? gelu_pkg::ONE_Q15
                         : lo_reg + gelu_pkg::TH_W'(interp[IP_W-1:gelu_pkg::SEG_BITS]);
        m_next = x6_reg[gelu_pkg::DATA_WIDTH-1]
               ? gelu_pkg::M_W'(gelu_pkg::ONE_Q15) - gelu_pkg::M_W'(th)
               : gelu_pkg::M_W'(gelu_pkg::ONE_Q15) + gelu_pkg::M_W'(th);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en6) v6_reg <= in_valid;
            if (en7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            x6_reg    <= in_beat.x;
            last6_reg <= in_beat.last;
            sat_reg   <= sat_next;
            lo_reg    <= lo_next;
            diff_reg  <= diff_next;
            frac_reg  <= in_beat.u[gelu_pkg::SEG_BITS-1:0];
        end
        if (en7)
        begin
            x7_reg    <= x6_reg;
            last7_reg <= last6_reg;
            m_reg     <= m_next;
        end
    end

    assign out_valid     = v7_reg;
    assign out_beat.x    = x7_reg;
    assign out_beat.last = last7_reg;
    assign out_beat.m    = m_reg;

    a_m_range: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> (m_reg <= gelu_pkg::ONE_Q16))
        else $error("gelu_tanh: scale factor above one");

    a_sat_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && en7 && sat_reg && !x6_reg[gelu_pkg::DATA_WIDTH-1])
        |=> (m_reg == gelu_pkg::ONE_Q16))
        else $error("gelu_tanh: clamped argument did not give tanh of one");

endmodule

FILE: src/gelu_out.sv
// gelu_out: final multiply by x, round to nearest, saturate, output register
module gelu_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gelu_pkg::scale_beat_t in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gelu_pkg::sample_t     activated,
    output logic                  last_out
);

    localparam int PROD_W = gelu_pkg::DATA_WIDTH + gelu_pkg::M_W + 1;
    localparam int Y_W    = PROD_W - 16;
    localparam logic signed [Y_W-1:0] Y_MAX =
        Y_W'((64'sd1 <<< (gelu_pkg::DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

    logic en8;
    logic out_valid_reg;
    gelu_pkg::sample_t activated_reg, activated_next;
    logic last_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [Y_W-1:0]    y;

    assign en8 = !out_valid_reg || out_ready;
    assign in_ready = en8;

    always_comb
    begin
        prod = PROD_W'(in_beat.x) * PROD_W'($signed({1'b0, in_beat.m}));
        rnd  = prod + PROD_W'(32768);
        y    = rnd[PROD_W-1:16];
        if (y > Y_MAX)
            activated_next = gelu_pkg::DATA_WIDTH'(Y_MAX);
        else if (y < Y_MIN)
            activated_next = gelu_pkg::DATA_WIDTH'(Y_MIN);
        else
            activated_next = gelu_pkg::DATA_WIDTH'(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en8)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en8)
        begin
            activated_reg <= activated_next;
            last_reg      <= in_beat.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign activated = activated_reg;
    assign last_out  = last_reg;

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && en8 && !in_beat.x[gelu_pkg::DATA_WIDTH-1])
        |=> !activated_reg[gelu_pkg::DATA_WIDTH-1])
        else $error("gelu_out: negative result for non-negative sample");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && en8 && in_beat.x[gelu_pkg::DATA_WIDTH-1])
        |=> (activated_reg == '0 || activated_reg[gelu_pkg::DATA_WIDTH-1]))
        else $error("gelu_out: positive result for negative sample");

endmodule
